// ===== hdl/itov_pkg.sv =====
package itov_pkg;

    // default width of every time value in nanoseconds
    localparam int TIME_WIDTH_DEF = 63;

    // width of the saturating overrun count
    localparam int OVR_WIDTH = 31;

    // operation of the shared adder
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ===== hdl/interval_timer_overrun_core.sv =====
// Interval timer with overrun count, on a nanosecond time base.
// Input channel (i_in_valid / o_in_ready): each transaction carries the
// current time i_now. Opcode 1 arms with i_new_value (relative to now, or
// absolute when i_absolute is set) and reload i_new_interval; a zero value
// disarms. Opcode 0 observes time and fires once the deadline is reached.
// Output channel (o_out_valid / i_out_ready): exactly one result transaction
// per input transaction, in order.
// Sequence: an arm transaction passes S_ARM_REM and, when relative, S_ARM_DL
// on its way to S_OUT and the output register; a time transaction that does
// not catch up passes S_T_CMP and S_REM, and a periodic expiry adds S_DIV,
// S_T_SUB and S_T_ADD. The expiry cost is set by the restoring divider that runs
// elapsed time over the interval one quotient bit per cycle on the single
// shared adder; one transaction is in work at a time, and o_in_ready rises
// the cycle after its result is loaded.
// A finished result sits in the output register; while the receiver stalls,
// the next transaction is still taken and worked, and it waits for the
// output register to drain before o_in_ready rises again.
// Reset (synchronous, active low) disarms the timer and clears deadline,
// interval and overrun; no result is pending afterwards.
module interval_timer_overrun_core #(
    parameter int TIME_WIDTH = itov_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic [TIME_WIDTH-1:0]          i_now,
    input  logic [TIME_WIDTH-1:0]          i_new_value,
    input  logic [TIME_WIDTH-1:0]          i_new_interval,
    input  logic                           i_absolute,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_fired,
    output logic [itov_pkg::OVR_WIDTH-1:0] o_overrun,
    output logic [TIME_WIDTH-1:0]          o_remaining,
    output logic [TIME_WIDTH-1:0]          o_period_out,
    output logic                           o_armed_out
);
    import itov_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int CW = $clog2(TW);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ARM_REM = 4'd1;
    localparam logic [3:0] S_ARM_DL  = 4'd2;
    localparam logic [3:0] S_T_CMP   = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_T_SUB   = 4'd5;
    localparam logic [3:0] S_T_ADD   = 4'd6;
    localparam logic [3:0] S_REM     = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    localparam logic [TW-1:0]        T_MAX   = {TW{1'b1}};
    localparam logic [OVR_WIDTH-1:0] OVR_MAX = {OVR_WIDTH{1'b1}};

    logic [3:0]           r_state, n_state;

    // timer state
    logic                 r_armed, n_armed;
    logic [TW-1:0]        r_deadline, n_deadline;
    logic [TW-1:0]        r_period, n_period;
    logic [OVR_WIDTH-1:0] r_overrun, n_overrun;

    // latched transaction
    logic                 r_op;
    logic [TW-1:0]        r_now, r_nv, r_ni;
    logic                 r_abs;

    // divider and result scratch
    logic [TW:0]          r_rem, n_rem;
    logic [TW-1:0]        r_quo, n_quo;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_fired, n_fired;
    logic [TW-1:0]        r_res_rem, n_res_rem;
    logic [TW-1:0]        r_res_per, n_res_per;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 out_load;

    // shared adder
    logic [TW:0]          alu_a, alu_b, alu_sum;
    t_alu_op              alu_op;
    logic                 alu_carry;
    logic [TW:0]          rem_sh;
    logic                 in_take;

    itov_alu #(.W(TW + 1)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_op    (alu_op),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign rem_sh     = {r_rem[TW-1:0], r_quo[TW-1]};
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // operand selection for the shared adder
    always_comb begin
        alu_a  = {1'b0, r_deadline};
        alu_b  = {1'b0, r_now};
        alu_op = ALU_SUB;
        unique case (r_state)
            S_ARM_DL: begin
                alu_a  = {1'b0, r_now};
                alu_b  = {1'b0, r_nv};
                alu_op = ALU_ADD;
            end
            S_T_CMP: begin
                alu_a = {1'b0, r_now};
                alu_b = {1'b0, r_deadline};
            end
            S_DIV: begin
                alu_a = rem_sh;
                alu_b = {1'b0, r_period};
            end
            S_T_SUB: begin
                alu_a = {1'b0, r_now};
                alu_b = r_rem;
            end
            S_T_ADD: begin
                alu_a  = r_rem;
                alu_b  = {1'b0, r_period};
                alu_op = ALU_ADD;
            end
            default: begin
                alu_a  = {1'b0, r_deadline};
                alu_b  = {1'b0, r_now};
                alu_op = ALU_SUB;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_armed    = r_armed;
        n_deadline = r_deadline;
        n_period   = r_period;
        n_overrun  = r_overrun;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_fired    = r_fired;
        n_res_rem  = r_res_rem;
        n_res_per  = r_res_per;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = i_opcode ? S_ARM_REM : S_T_CMP;
                end
            end
            S_ARM_REM: begin
                // old remaining time, then install the new setting
                n_res_rem = (r_armed && alu_carry) ? alu_sum[TW-1:0] : '0;
                n_res_per = r_period;
                n_fired   = 1'b0;
                n_period  = r_ni;
                n_overrun = '0;
                n_armed   = (r_nv != '0);
                if (r_nv == '0) begin
                    n_deadline = '0;
                    n_state    = S_OUT;
                end else if (r_abs) begin
                    n_deadline = r_nv;
                    n_state    = S_OUT;
                end else begin
                    n_state = S_ARM_DL;
                end
            end
            S_ARM_DL: begin
                // relative expiry, saturating at the maximum time
                n_deadline = alu_sum[TW] ? T_MAX : alu_sum[TW-1:0];
                n_state    = S_OUT;
            end
            S_T_CMP: begin
                n_fired = 1'b0;
                n_state = S_REM;
                if (r_armed && alu_carry) begin
                    n_fired = 1'b1;
                    if (r_period == '0) begin
                        n_armed   = 1'b0;
                        n_overrun = '0;
                    end else begin
                        n_quo   = alu_sum[TW-1:0];
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // one restoring step: elapsed over period
                n_rem = alu_carry ? alu_sum : rem_sh;
                n_quo = {r_quo[TW-2:0], alu_carry};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(TW - 1)) begin
                    n_state = S_T_SUB;
                end
            end
            S_T_SUB: begin
                // now minus remainder; quotient counts the skipped periods
                n_rem = alu_sum;
                if ((|r_quo[TW-1:OVR_WIDTH]) || (&r_quo[OVR_WIDTH-1:0])) begin
                    n_overrun = OVR_MAX;
                end else begin
                    n_overrun = r_quo[OVR_WIDTH-1:0];
                end
                n_state = S_T_ADD;
            end
            S_T_ADD: begin
                // next deadline one period past the last missed one
                n_deadline = alu_sum[TW] ? T_MAX : alu_sum[TW-1:0];
                n_state    = S_REM;
            end
            S_REM: begin
                n_res_rem = (r_armed && alu_carry) ? alu_sum[TW-1:0] : '0;
                n_res_per = r_period;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_deadline  <= '0;
            r_period    <= '0;
            r_overrun   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_armed     <= n_armed;
            r_deadline  <= n_deadline;
            r_period    <= n_period;
            r_overrun   <= n_overrun;
            r_out_valid <= n_out_valid;
        end
    end

    // transaction latch and scratch
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_opcode;
            r_now <= i_now;
            r_nv  <= i_new_value;
            r_ni  <= i_new_interval;
            r_abs <= i_absolute;
        end
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_fired   <= n_fired && !r_op;
        r_res_rem <= n_res_rem;
        r_res_per <= n_res_per;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_fired      <= r_fired;
            o_overrun    <= r_overrun;
            o_remaining  <= r_res_rem;
            o_period_out <= r_res_per;
            o_armed_out  <= r_armed;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/itov_alu.sv =====
module itov_alu #(
    parameter int W = itov_pkg::TIME_WIDTH_DEF + 1
) (
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  itov_pkg::t_alu_op i_op,
    output logic [W-1:0]      o_sum,
    output logic              o_carry
);
    import itov_pkg::*;

    logic [W-1:0] b_eff;
    logic [W:0]   full;

    // one adder serves add and subtract; on subtract carry means a >= b
    assign b_eff   = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign full    = {1'b0, i_a} + {1'b0, b_eff} + {{W{1'b0}}, (i_op == ALU_SUB)};
    assign o_sum   = full[W-1:0];
    assign o_carry = full[W];

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import itov_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam int OW = OVR_WIDTH;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
    localparam logic [OW-1:0] OVR_MAX = {OW{1'b1}};
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic {
        OP_OBSERVE = 1'b0,
        OP_ARM     = 1'b1
    } timer_op_e;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_e;

    typedef struct packed {
        logic          fired;
        logic [OW-1:0] overrun;
        logic [TW-1:0] remaining;
        logic [TW-1:0] period_out;
        logic          armed;
    } timer_result_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    logic          i_opcode;
    logic [TW-1:0] i_now;
    logic [TW-1:0] i_new_value;
    logic [TW-1:0] i_new_interval;
    logic          i_absolute;
    logic          o_out_valid;
    logic          i_out_ready;
    logic          o_fired;
    logic [OW-1:0] o_overrun;
    logic [TW-1:0] o_remaining;
    logic [TW-1:0] o_period_out;
    logic          o_armed_out;

    // timer state as the block should hold it
    logic          tmr_armed    = 1'b0;
    logic [TW-1:0] tmr_deadline = '0;
    logic [TW-1:0] tmr_period   = '0;
    logic [OW-1:0] tmr_overrun  = '0;

    timer_result_t pending_results[$];

    int       mismatch_count    = 0;
    int       items_accepted    = 0;
    bit       tx_bursty         = 1'b0;
    int       burst_left        = 0;
    rx_mode_e rx_mode           = RX_ALWAYS;
    logic [7:0] stall_pattern   = 8'hb5;
    int       hold_cycles_left  = 0;

    timer_result_t got_result;
    timer_result_t want_result;

    interval_timer_overrun_core #(
        .TIME_WIDTH(TW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_now          (i_now),
        .i_new_value    (i_new_value),
        .i_new_interval (i_new_interval),
        .i_absolute     (i_absolute),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fired        (o_fired),
        .o_overrun      (o_overrun),
        .o_remaining    (o_remaining),
        .o_period_out   (o_period_out),
        .o_armed_out    (o_armed_out)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // saturating add of two time values
    function automatic logic [TW-1:0] sat_time_add(input logic [TW:0] a, input logic [TW:0] b);
        logic [TW+1:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[TW-1:0];
    endfunction

    // time left to the deadline, zero when disarmed or passed
    function automatic logic [TW-1:0] time_to_deadline(input logic [TW-1:0] now);
        return (tmr_armed && tmr_deadline > now) ? tmr_deadline - now : '0;
    endfunction

    // advance the timer by one transaction and give its result
    function automatic timer_result_t predict_timer(
        input timer_op_e     op,
        input logic [TW-1:0] now,
        input logic [TW-1:0] nv,
        input logic [TW-1:0] ni,
        input logic          absf
    );
        timer_result_t r;
        logic [TW:0] periods;
        logic [TW:0] extra;
        r = '0;
        if (op == OP_ARM) begin
            r.remaining  = time_to_deadline(now);
            r.period_out = tmr_period;
            tmr_period   = ni;
            tmr_armed    = (nv != '0);
            if (!tmr_armed) begin
                tmr_deadline = '0;
            end else if (absf) begin
                tmr_deadline = nv;
            end else begin
                tmr_deadline = sat_time_add({1'b0, now}, {1'b0, nv});
            end
            tmr_overrun = '0;
        end else begin
            // expiry, with catch-up over skipped periods
            if (tmr_armed && now >= tmr_deadline) begin
                r.fired = 1'b1;
                if (tmr_period == '0) begin
                    tmr_armed   = 1'b0;
                    tmr_overrun = '0;
                end else begin
                    periods = {1'b0, now - tmr_deadline} / {1'b0, tmr_period} + 1'b1;
                    extra   = periods - 1'b1;
                    tmr_deadline = sat_time_add({1'b0, tmr_deadline},
                                                periods * {1'b0, tmr_period});
                    tmr_overrun  = (extra > {1'b0, {(TW - OW){1'b0}}, OVR_MAX}) ?
                                   OVR_MAX : extra[OW-1:0];
                end
            end
            r.remaining  = time_to_deadline(now);
            r.period_out = tmr_period;
        end
        r.overrun = tmr_overrun;
        r.armed   = tmr_armed;
        return r;
    endfunction

    // random time value of a given bit length
    function automatic logic [TW-1:0] rand_time(input int bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (bits < 64) begin
            v = v & ((64'd1 << bits) - 64'd1);
        end
        return v[TW-1:0];
    endfunction

    function automatic string result_text(input timer_result_t r);
        return $sformatf("fired=%0d overrun=%0d remaining=%0d period=%0d armed=%0d",
                         r.fired, r.overrun, r.remaining, r.period_out, r.armed);
    endfunction

    // send one transaction, bursts with random gaps when enabled
    task automatic send_item(
        input timer_op_e     op,
        input logic [TW-1:0] now,
        input logic [TW-1:0] nv,
        input logic [TW-1:0] ni,
        input logic          absf
    );
        if (tx_bursty && burst_left == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_now          <= now;
        i_new_value    <= nv;
        i_new_interval <= ni;
        i_absolute     <= absf;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_timer(op, now, nv, ni, absf));
        items_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // time observation with random ignored fields
    task automatic observe(input logic [TW-1:0] now);
        send_item(OP_OBSERVE, now, rand_time(TW), rand_time(TW), 1'($urandom_range(0, 1)));
    endtask

    // stop sending until every result is back
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: long hold-off, or its current stall pattern
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles_left > 0) begin
                hold_cycles_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        i_out_ready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        i_out_ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        i_out_ready <= stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_result = {o_fired, o_overrun, o_remaining, o_period_out, o_armed_out};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("result transaction with none pending: %s", result_text(got_result));
                end
            end else begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result mismatch");
                        $display("  expected %s", result_text(want_result));
                        $display("  actual   %s", result_text(got_result));
                    end
                end
            end
        end
    end

    // time items before anything is armed
    task automatic test_disarmed_observe();
        observe('0);
        observe(TIME_MAX);
        wait_results_drained();
    endtask

    // relative one-shot, expiring exactly at its deadline
    task automatic test_one_shot();
        send_item(OP_ARM, 1000, 100, 0, 1'b0);
        observe(1050);
        observe(1100);
        wait_results_drained();
    endtask

    // periodic timer with skipped periods, then re-armed while running
    task automatic test_periodic_catch_up();
        send_item(OP_ARM, 0, 10, 7, 1'b0);
        observe(10);
        observe(100);
        send_item(OP_ARM, 100, TIME_MAX, TIME_MAX, 1'b1);
        wait_results_drained();
    endtask

    // absolute expiry at or before now fires on the next time item only
    task automatic test_arm_in_past();
        send_item(OP_ARM, 1000, 5, 0, 1'b1);
        observe(1000);
        send_item(OP_ARM, 2000, 2000, 0, 1'b1);
        observe(2000);
        wait_results_drained();
    endtask

    // deadline and overrun saturation
    task automatic test_saturation();
        // relative expiry past the maximum time
        send_item(OP_ARM, TIME_MAX - 10, TIME_MAX, 3, 1'b0);
        observe(TIME_MAX);
        observe(TIME_MAX);
        // overrun count past its maximum
        send_item(OP_ARM, 0, 1, 1, 1'b1);
        observe(TW'(64'd1 << 40));
        observe(TIME_MAX);
        observe(TIME_MAX);
        wait_results_drained();
    endtask

    // zero value disarms but still loads the interval
    task automatic test_disarm();
        send_item(OP_ARM, 500, 0, 55, 1'b1);
        observe(600);
        send_item(OP_ARM, 600, 0, 0, 1'b0);
        observe(TIME_MAX);
        wait_results_drained();
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_long_hold();
        logic [TW-1:0] t;
        tx_bursty = 1'b0;
        t = rand_time(20);
        hold_cycles_left = HOLD_CYCLES;
        send_item(OP_ARM, t, 50, 13, 1'b0);
        repeat (7) begin
            t = t + rand_time(6);
            observe(t);
        end
        wait_results_drained();
    endtask

    // random sequences: mostly arm followed by advancing time
    task automatic test_random_traffic();
        int            start_count;
        int            phase_end;
        bit            first_phase;
        int            kind;
        int            mag;
        int            mag_lo;
        int            mag_hi;
        logic [TW-1:0] clk_now;
        logic [TW-1:0] step;
        logic [TW-1:0] nv;
        logic [TW-1:0] ni;
        logic          absf;
        start_count = items_accepted;
        phase_end   = items_accepted;
        first_phase = 1'b1;
        clk_now     = rand_time(20);
        while (items_accepted - start_count < RANDOM_ITEMS) begin
            // idling setup for the next stretch
            if (items_accepted >= phase_end) begin
                phase_end = items_accepted + $urandom_range(60, 140);
                if (first_phase) begin
                    tx_bursty   = 1'b0;
                    rx_mode     = RX_ALWAYS;
                    first_phase = 1'b0;
                end else begin
                    tx_bursty     = ($urandom_range(0, 3) != 0);
                    rx_mode       = rx_mode_e'($urandom_range(0, 2));
                    stall_pattern = 8'($urandom) | 8'h01;
                end
            end
            if ($urandom_range(0, 19) == 0 || (clk_now == TIME_MAX && $urandom_range(0, 1))) begin
                clk_now = rand_time($urandom_range(1, TW));
            end
            kind   = $urandom_range(0, 9);
            mag    = $urandom_range(1, TW);
            mag_lo = (mag > 2) ? mag - 2 : 1;
            mag_hi = (mag + 4 < TW) ? mag + 4 : TW;
            if (kind <= 6) begin
                // well-formed: arm, then time moving forward
                absf = 1'($urandom_range(0, 1));
                nv   = rand_time(mag) | TW'(1);
                if (absf) begin
                    nv = clk_now + nv;
                end
                ni = ($urandom_range(0, 3) == 0) ? '0 : rand_time(mag);
                send_item(OP_ARM, clk_now, nv, ni, absf);
                repeat ($urandom_range(2, 8)) begin
                    if ($urandom_range(0, 15) == 0) begin
                        step = rand_time(TW);
                    end else begin
                        step = rand_time($urandom_range(mag_lo, mag_hi));
                    end
                    clk_now = (clk_now > TIME_MAX - step) ? TIME_MAX : clk_now + step;
                    observe(clk_now);
                end
            end else if (kind == 7) begin
                // noise over every field
                repeat ($urandom_range(1, 4)) begin
                    send_item(timer_op_e'($urandom_range(0, 1)), rand_time(TW), rand_time(TW),
                              rand_time(TW), 1'($urandom_range(0, 1)));
                end
            end else begin
                // broken sequence: disarm, re-arm, time going backwards
                send_item(OP_ARM, clk_now, '0, rand_time(mag), 1'($urandom_range(0, 1)));
                observe(clk_now);
                send_item(OP_ARM, clk_now, rand_time(mag), rand_time(mag), 1'b0);
                send_item(OP_ARM, clk_now, rand_time(mag), rand_time(mag), 1'b0);
                observe(clk_now - rand_time(mag));
                observe(clk_now);
            end
        end
        wait_results_drained();
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_OBSERVE;
        i_now          = '0;
        i_new_value    = '0;
        i_new_interval = '0;
        i_absolute     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        test_disarmed_observe();
        test_one_shot();
        test_periodic_catch_up();
        test_arm_in_past();
        test_saturation();
        test_disarm();
        test_long_hold();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run time limit
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/itov_pkg.sv
hdl/itov_alu.sv
hdl/interval_timer_overrun_core.sv
tb/tb_top.sv
